/* rtl/core/hsd_pkg.sv */
// hsd_pkg: types, codes and constant helpers of the hamming sec-ded decoder
// no dependencies; used by hsd_syndrome, hsd_correct and the top level
`default_nettype none

package hsd_pkg;

    localparam int IN_W   = 32;
    localparam int DATA_W = 26;
    localparam int SYN_W  = 5;
    localparam int LEN_W  = 6;
    localparam int CFG_W  = 6;
    localparam int MIN_LEN = 3;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_CORRECTED   = 2'd1,
        STATUS_UNCORRECTED = 2'd2
    } status_t;

    typedef enum logic {
        REG_MODE = 1'b0,
        REG_LEN  = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_bits;
        logic [SYN_W-1:0]  syndrome;
        logic              overall_parity;
        status_t           status;
    } result_t;

    function automatic bit is_pow2(input int v);
        return (v != 0) && ((v & (v - 1)) == 0);
    endfunction

    // positions whose index has bit k set, bit p-1 for position p
    function automatic logic [63:0] pos_mask(input int k);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 64; i++) begin
            m[i] = (((i + 1) >> k) & 1) != 0;
        end
        return m;
    endfunction

    // position of the j-th data bit
    function automatic int data_pos(input int j);
        int cnt;
        int pos;
        cnt = 0;
        pos = 0;
        for (int p = 3; p < 128; p++) begin
            if (!is_pow2(p)) begin
                if (cnt == j && pos == 0) begin
                    pos = p;
                end
                cnt++;
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/hsd_syndrome.sv */
// hsd_syndrome: masks the codeword to the code length, forms syndrome and parity
// depends on hsd_pkg
`default_nettype none

module hsd_syndrome #(
    parameter int MAX_CODE_BITS = 32
) (
    input  wire logic [hsd_pkg::IN_W-1:0]           codeword,
    input  wire logic [hsd_pkg::LEN_W-1:0]          code_len,
    output logic [MAX_CODE_BITS-1:0]                word,
    output logic [$clog2(MAX_CODE_BITS)-1:0]        syn,
    output logic                                    par
);

    localparam int SW = $clog2(MAX_CODE_BITS);

    for (genvar i = 0; i < MAX_CODE_BITS; i++) begin : g_word
        if (i < hsd_pkg::IN_W) begin : g_in
            assign word[i] = codeword[i] & (code_len > hsd_pkg::LEN_W'(i));
        end
        else begin : g_zero
            assign word[i] = 1'b0;
        end
    end

    for (genvar k = 0; k < SW; k++) begin : g_syn
        localparam logic [63:0] MASK = hsd_pkg::pos_mask(k);
        // bit k only counts while 2^k is below the code length
        assign syn[k] = (^(word & MASK[MAX_CODE_BITS-1:0]))
                      & ({1'b0, code_len} > (hsd_pkg::LEN_W + 1)'(1 << k));
    end

    assign par = ^word;

endmodule

`default_nettype wire

/* rtl/core/hsd_correct.sv */
// hsd_correct: status decision, single bit flip and data bit packing
// depends on hsd_pkg
`default_nettype none

module hsd_correct #(
    parameter int MAX_CODE_BITS = 32
) (
    input  wire logic [MAX_CODE_BITS-1:0]           word,
    input  wire logic [$clog2(MAX_CODE_BITS)-1:0]   syn,
    input  wire logic                               par,
    input  wire logic                               mode,
    input  wire logic [hsd_pkg::LEN_W-1:0]          code_len,
    output hsd_pkg::result_t                        res
);

    localparam int SW     = $clog2(MAX_CODE_BITS);
    localparam int SX_W   = hsd_pkg::LEN_W + 1;
    localparam int DATA_N = MAX_CODE_BITS - $clog2(MAX_CODE_BITS + 1);

    logic [SX_W-1:0]                 syn_x;
    logic                            flip;
    hsd_pkg::status_t                status;
    logic [MAX_CODE_BITS-1:0]        fixed;
    logic [hsd_pkg::DATA_W-1:0]      data;
    logic [hsd_pkg::SYN_W-1:0]       syn_out;

    assign syn_x = SX_W'(syn);

    always_comb
    begin
        flip   = 1'b0;
        status = hsd_pkg::STATUS_OK;
        if (syn_x == '0)
        begin
            status = (mode && par) ? hsd_pkg::STATUS_CORRECTED : hsd_pkg::STATUS_OK;
        end
        else if (syn_x > {1'b0, code_len})
        begin
            status = hsd_pkg::STATUS_UNCORRECTED;
        end
        else if (!mode || par)
        begin
            flip   = 1'b1;
            status = hsd_pkg::STATUS_CORRECTED;
        end
        else
        begin
            status = hsd_pkg::STATUS_UNCORRECTED;
        end
    end

    for (genvar i = 0; i < MAX_CODE_BITS; i++) begin : g_fix
        assign fixed[i] = word[i] ^ (flip && (syn_x == SX_W'(i + 1)));
    end

    for (genvar j = 0; j < hsd_pkg::DATA_W; j++) begin : g_data
        if (j < DATA_N) begin : g_bit
            localparam int POS = hsd_pkg::data_pos(j);
            assign data[j] = fixed[POS-1];
        end
        else begin : g_zero
            assign data[j] = 1'b0;
        end
    end

    for (genvar j = 0; j < hsd_pkg::SYN_W; j++) begin : g_syn
        if (j < SW) begin : g_bit
            assign syn_out[j] = syn[j];
        end
        else begin : g_zero
            assign syn_out[j] = 1'b0;
        end
    end

    always_comb
    begin
        res.data_bits      = data;
        res.syndrome       = syn_out;
        res.overall_parity = par;
        res.status         = status;
    end

endmodule

`default_nettype wire

/* rtl/core/hamming_secded_decoder_top.sv */
// hamming_secded_decoder_top: hamming sec-ded decoder, one codeword per clock
// throughput one item every cycle, busy stays low
// the path is an input register, one syndrome/correct pass and a result register
// rst_n clears the valid flags, mode (distance 3) and code length (32)
// depends on hsd_pkg, hsd_syndrome, hsd_correct
`default_nettype none

module hamming_secded_decoder_top #(
    parameter int MAX_CODE_BITS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [hsd_pkg::IN_W-1:0]       codeword,
    input  wire logic                           wr_en,
    input  wire logic                           wr_index,
    input  wire logic [hsd_pkg::CFG_W-1:0]      wr_data,
    output logic                                done,
    output logic [hsd_pkg::DATA_W-1:0]          data_bits,
    output logic [hsd_pkg::SYN_W-1:0]           syndrome,
    output logic                                overall_parity,
    output logic [1:0]                          status
);

    localparam int SW = $clog2(MAX_CODE_BITS);

    logic                           mode_reg;
    logic [hsd_pkg::LEN_W-1:0]      len_reg;
    logic                           in_valid_reg;
    logic [hsd_pkg::IN_W-1:0]       codeword_reg;
    logic                           done_reg;
    hsd_pkg::result_t               res_reg;
    hsd_pkg::result_t               res_next;
    logic [hsd_pkg::LEN_W-1:0]      code_len;
    logic [MAX_CODE_BITS-1:0]       word;
    logic [SW-1:0]                  syn;
    logic                           par;

    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            len_reg  <= hsd_pkg::LEN_W'(32);
        end
        else if (wr_en)
        begin
            case (wr_index)
                hsd_pkg::REG_MODE: mode_reg <= wr_data[0];
                hsd_pkg::REG_LEN:  len_reg  <= wr_data[hsd_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp to the supported range
    always_comb
    begin
        if (len_reg < hsd_pkg::LEN_W'(hsd_pkg::MIN_LEN))
        begin
            code_len = hsd_pkg::LEN_W'(hsd_pkg::MIN_LEN);
        end
        else if (len_reg > hsd_pkg::LEN_W'(MAX_CODE_BITS))
        begin
            code_len = hsd_pkg::LEN_W'(MAX_CODE_BITS);
        end
        else
        begin
            code_len = len_reg;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            codeword_reg <= codeword;
        end
    end

    hsd_syndrome #(
        .MAX_CODE_BITS(MAX_CODE_BITS)
    ) u_syndrome (
        .codeword (codeword_reg),
        .code_len (code_len),
        .word     (word),
        .syn      (syn),
        .par      (par)
    );

    hsd_correct #(
        .MAX_CODE_BITS(MAX_CODE_BITS)
    ) u_correct (
        .word     (word),
        .syn      (syn),
        .par      (par),
        .mode     (mode_reg),
        .code_len (code_len),
        .res      (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign done           = done_reg;
    assign data_bits      = res_reg.data_bits;
    assign syndrome       = res_reg.syndrome;
    assign overall_parity = res_reg.overall_parity;
    assign status         = res_reg.status;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##2 done)
        else $error("accepted item not delivered after two cycles");

    a_ok_zero_syn: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == hsd_pkg::STATUS_OK) |-> (syndrome == '0))
        else $error("clean status with nonzero syndrome");

    a_uncorr_d3: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == hsd_pkg::STATUS_UNCORRECTED && !mode_reg) |-> (syndrome != '0))
        else $error("distance 3 uncorrectable with zero syndrome");

    a_parity_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == hsd_pkg::STATUS_CORRECTED && syndrome == '0)
            |-> (overall_parity && mode_reg))
        else $error("parity bit correction without odd parity in distance 4");
`endif

endmodule

`default_nettype wire
